/* src/lsa_pkg.sv */
// ----------------------------------------------------------------------------
// Local sequence aligner package
// Shared widths, request codes and the item passed from front to back.
// ----------------------------------------------------------------------------
package lsa_pkg;

  localparam int unsigned MaxLen  = 32;
  localparam int unsigned IdxW    = $clog2(MaxLen);
  localparam int unsigned CntW    = $clog2(MaxLen + 1);
  localparam int unsigned ScoreW  = 13;
  localparam int unsigned CellW   = 16;
  localparam int unsigned ColW    = $clog2(2 * MaxLen);
  localparam int unsigned ColCntW = $clog2(2 * MaxLen + 1);
  localparam logic [7:0]  GapChar = 8'd45;

  typedef enum logic [1:0] {
    REQ_FIRST  = 2'd0,
    REQ_SECOND = 2'd1,
    REQ_RUN    = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_MATCH    = 2'd0,
    CFG_MISMATCH = 2'd1,
    CFG_GAP      = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    MV_LEFT = 2'd1,
    MV_UP   = 2'd2,
    MV_DIAG = 2'd3,
    MV_NONE = 2'd0
  } move_e;

  // Item handed from the front part to the back part.
  typedef struct packed {
    logic            run;
    logic            second;
    logic [7:0]      symbol;
  } cmd_t;

endpackage

/* src/lsa_front.sv */
// ----------------------------------------------------------------------------
// Local sequence aligner front
// Accepts request items, drops unknown codes and queues the rest.
// ----------------------------------------------------------------------------
module lsa_front import lsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type_i,
  input  logic [7:0] symbol_i,
  output logic       cmd_valid_o,
  input  logic       cmd_pop_i,
  output cmd_t       cmd_o
);

  cmd_t       fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall    = (cnt_q == 2'd2);
  assign push        = in_valid && !in_stall && (req_type_i != REQ_NONE);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= '{run: (req_type_i == REQ_RUN), second: (req_type_i == REQ_SECOND),
                        symbol: symbol_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (cmd_pop_i) rd_q <= ~rd_q;
      case ({push, cmd_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* src/lsa_back.sv */
// ----------------------------------------------------------------------------
// Local sequence aligner back
// Holds the sequences, fills the score matrix one cell a cycle, traces back
// and streams the aligned columns out in forward order.
// ----------------------------------------------------------------------------
module lsa_back import lsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  cmd_t              cmd_i,
  input  logic [7:0]        match_i,
  input  logic [7:0]        mismatch_i,
  input  logic [7:0]        gap_i,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        first_symbol_o,
  output logic [7:0]        second_symbol_o,
  output logic              first_is_gap_o,
  output logic              second_is_gap_o,
  output logic [ScoreW-1:0] best_score_o,
  output logic              empty_res_o,
  output logic              last_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_FILL, ST_TB_RD, ST_TB, ST_OUT_RD, ST_OUT
  } state_e;

  state_e state_q;

  logic [7:0]  seq1_q [MaxLen];
  logic [7:0]  seq2_q [MaxLen];
  logic [CntW-1:0] n1_q, n2_q;

  // Column j of the score row is held at entry j-1; column zero is always zero.
  logic [ScoreW-1:0] row_q [MaxLen];
  logic [2:0]        ptr_mem [MaxLen*MaxLen];
  logic [2:0]        ptr_rd_q;
  logic [17:0]       col_mem [2*MaxLen];
  logic [17:0]       col_rd_q;

  logic [CntW-1:0]    i_q, j_q;
  logic [ScoreW-1:0]  diag_q, left_q;
  logic [ScoreW-1:0]  best_q;
  logic [CntW-1:0]    bi_q, bj_q;
  logic               found_q;
  logic [ColCntW-1:0] ncol_q, k_q;

  // Cell update.
  logic signed [CellW-1:0] s_up, s_left, s_diag, score;
  logic [1:0]              code;
  logic [2*IdxW-1:0]       waddr, raddr;
  logic [IdxW-1:0]         ii, jj;

  assign ii = IdxW'(i_q - CntW'(1));
  assign jj = IdxW'(j_q - CntW'(1));

  always_comb begin
    s_up   = $signed({3'b000, row_q[jj]})   + CellW'($signed(gap_i));
    s_left = $signed({3'b000, left_q})      + CellW'($signed(gap_i));
    s_diag = $signed({3'b000, diag_q}) +
             ((seq1_q[ii] == seq2_q[jj]) ? CellW'($signed(match_i))
                                        : CellW'($signed(mismatch_i)));
    score = '0;
    if (s_up > score) score = s_up;
    if (s_left > score) score = s_left;
    if (s_diag > score) score = s_diag;
    if (score == s_up)        code = MV_UP;
    else if (score == s_left) code = MV_LEFT;
    else                      code = MV_DIAG;
  end

  assign waddr     = {ii, jj};
  assign raddr     = {ii, jj};
  assign cmd_pop_o = cmd_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i && !cmd_i.run) begin
      if (!cmd_i.second && n1_q < CntW'(MaxLen)) seq1_q[n1_q[IdxW-1:0]] <= cmd_i.symbol;
      if (cmd_i.second && n2_q < CntW'(MaxLen))  seq2_q[n2_q[IdxW-1:0]] <= cmd_i.symbol;
    end
    if (state_q == ST_INIT) row_q[jj] <= '0;
    if (state_q == ST_FILL) begin
      ptr_mem[waddr] <= {(score != 0), code};
      row_q[jj]      <= score[ScoreW-1:0];
    end
    ptr_rd_q <= ptr_mem[raddr];
    if (state_q == ST_TB) begin
      case (move_e'(ptr_rd_q[1:0]))
        MV_DIAG: col_mem[ncol_q[ColW-1:0]] <= {2'b00, seq2_q[jj], seq1_q[ii]};
        MV_LEFT: col_mem[ncol_q[ColW-1:0]] <= {2'b01, seq2_q[jj], GapChar};
        default: col_mem[ncol_q[ColW-1:0]] <= {2'b10, GapChar, seq1_q[ii]};
      endcase
    end
    col_rd_q <= col_mem[ColW'(ncol_q - k_q - ColCntW'(1))];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n1_q      <= '0;
      n2_q      <= '0;
      i_q       <= '0;
      j_q       <= '0;
      diag_q    <= '0;
      left_q    <= '0;
      best_q    <= '0;
      bi_q      <= '0;
      bj_q      <= '0;
      found_q   <= 1'b0;
      ncol_q    <= '0;
      k_q       <= '0;
      out_valid <= 1'b0;
      first_symbol_o  <= '0;
      second_symbol_o <= '0;
      first_is_gap_o  <= 1'b0;
      second_is_gap_o <= 1'b0;
      best_score_o    <= '0;
      empty_res_o     <= 1'b0;
      last_o          <= 1'b0;
    end else begin
      // In the output state the valid flag is either reloaded or held stalled.
      if (out_valid && !out_stall && state_q != ST_OUT) out_valid <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.run) begin
              best_q  <= '0;
              bi_q    <= '0;
              bj_q    <= '0;
              found_q <= 1'b0;
              ncol_q  <= '0;
              j_q     <= '0;
              state_q <= ST_INIT;
            end else if (!cmd_i.second) begin
              if (n1_q < CntW'(MaxLen)) n1_q <= n1_q + CntW'(1);
            end else begin
              if (n2_q < CntW'(MaxLen)) n2_q <= n2_q + CntW'(1);
            end
          end
        end
        ST_INIT: begin
          if (j_q == n2_q) begin
            i_q    <= CntW'(1);
            j_q    <= CntW'(1);
            diag_q <= '0;
            left_q <= '0;
            state_q <= (n1_q == 0 || n2_q == 0) ? ST_TB_RD : ST_FILL;
            if (n1_q == 0 || n2_q == 0) begin
              i_q <= '0;
              j_q <= '0;
            end
          end else begin
            j_q <= j_q + CntW'(1);
          end
        end
        ST_FILL: begin
          if (!found_q || score[ScoreW-1:0] > best_q) begin
            found_q <= 1'b1;
            best_q  <= score[ScoreW-1:0];
            bi_q    <= i_q;
            bj_q    <= j_q;
          end
          if (j_q == n2_q) begin
            j_q    <= CntW'(1);
            diag_q <= '0;
            left_q <= '0;
            if (i_q == n1_q) begin
              state_q <= ST_TB_RD;
              i_q     <= (found_q && !(score[ScoreW-1:0] > best_q)) ? bi_q : i_q;
              j_q     <= (found_q && !(score[ScoreW-1:0] > best_q)) ? bj_q : j_q;
            end else begin
              i_q <= i_q + CntW'(1);
            end
          end else begin
            diag_q <= row_q[jj];
            left_q <= score[ScoreW-1:0];
            j_q    <= j_q + CntW'(1);
          end
          ncol_q <= '0;
        end
        ST_TB_RD: begin
          // The pointer read address follows i and j; this state waits for the registered read data.
          state_q <= (i_q == 0 || j_q == 0) ? ST_OUT_RD : ST_TB;
          k_q     <= '0;
        end
        ST_TB: begin
          if (!ptr_rd_q[2]) begin
            state_q <= ST_OUT_RD;
          end else begin
            ncol_q <= ncol_q + ColCntW'(1);
            case (move_e'(ptr_rd_q[1:0]))
              MV_DIAG: begin i_q <= i_q - CntW'(1); j_q <= j_q - CntW'(1); end
              MV_LEFT: j_q <= j_q - CntW'(1);
              default: i_q <= i_q - CntW'(1);
            endcase
            state_q <= ST_TB_RD;
          end
          k_q <= '0;
        end
        ST_OUT_RD: begin
          if (!out_valid || !out_stall) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            best_score_o <= best_q;
            if (ncol_q == 0) begin
              first_symbol_o  <= '0;
              second_symbol_o <= '0;
              first_is_gap_o  <= 1'b0;
              second_is_gap_o <= 1'b0;
              empty_res_o     <= 1'b1;
              last_o          <= 1'b1;
            end else begin
              first_symbol_o  <= col_rd_q[7:0];
              second_symbol_o <= col_rd_q[15:8];
              first_is_gap_o  <= col_rd_q[16];
              second_is_gap_o <= col_rd_q[17];
              empty_res_o     <= 1'b0;
              last_o          <= (k_q + ColCntW'(1) == ncol_q);
            end
            if (ncol_q == 0 || k_q + ColCntW'(1) == ncol_q) begin
              n1_q    <= '0;
              n2_q    <= '0;
              state_q <= ST_IDLE;
            end else begin
              k_q     <= k_q + ColCntW'(1);
              state_q <= ST_OUT_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/local_sequence_aligner.sv */
// ----------------------------------------------------------------------------
// Local sequence aligner
// Smith-Waterman local alignment with linear gap score.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/stall   | req_type_i, symbol_i
// out     | output    | out_valid/stall  | columns, best score, flags
// cfg     | input     | cfg_valid/ready  | cfg_index_i, cfg_data_i
//
// A load item is stored while the back is idle. A run item clears the row,
// fills the matrix (one cell a cycle), then passes a read state and a
// traceback state per traceback step and a read state and an output state
// per result. Reset leaves the sequences empty and the registers at their
// defaults. The output register holds a result while out_stall is high; the
// two-entry queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
module local_sequence_aligner import lsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        symbol_i,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        first_symbol_o,
  output logic [7:0]        second_symbol_o,
  output logic              first_is_gap_o,
  output logic              second_is_gap_o,
  output logic [ScoreW-1:0] best_score_o,
  output logic              empty_res_o,
  output logic              last_o
);

  logic [7:0] match_q, mismatch_q, gap_q;
  logic       cmd_valid, cmd_pop;
  cmd_t       cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q    <= 8'd2;
      mismatch_q <= 8'hFF;
      gap_q      <= 8'hFF;
    end else if (cfg_valid) begin
      case (cfg_e'(cfg_index_i))
        CFG_MATCH:    match_q    <= cfg_data_i;
        CFG_MISMATCH: mismatch_q <= cfg_data_i;
        CFG_GAP:      gap_q      <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  lsa_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .req_type_i, .symbol_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  lsa_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .match_i(match_q), .mismatch_i(mismatch_q), .gap_i(gap_q),
    .out_valid, .out_stall, .first_symbol_o, .second_symbol_o,
    .first_is_gap_o, .second_is_gap_o, .best_score_o, .empty_res_o, .last_o
  );

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Local sequence aligner testbench
// Loads symbol sequences, runs local alignments under several score settings
// and checks every aligned column against a built-in scoring predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import lsa_pkg::*;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] symbol;
  } req_item_t;

  typedef struct packed {
    logic [7:0]        first_symbol;
    logic [7:0]        second_symbol;
    logic              first_is_gap;
    logic              second_is_gap;
    logic [ScoreW-1:0] best_score;
    logic              empty_res;
    logic              last;
  } column_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type_i = '0;
  logic [7:0] symbol_i = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] first_symbol_o, second_symbol_o;
  logic first_is_gap_o, second_is_gap_o, empty_res_o, last_o;
  logic [ScoreW-1:0] best_score_o;

  local_sequence_aligner dut (.*);

  always #10 clk_i = ~clk_i;

  req_item_t pending_reqs[$];
  column_t   expected_columns[$];
  int  error_count = 0;
  int  column_count = 0;
  int  run_count = 0;
  int  idle_count = 0;
  bit  quiet = 1'b0;
  bit  hold_request = 1'b0;
  bit  hold_active = 1'b0;

  // Predictor state.
  int        match_val = 2, mismatch_val = -1, gap_val = -1;
  logic [7:0] seq_a[MaxLen], seq_b[MaxLen];
  int        len_a = 0, len_b = 0;

  function automatic void predict_alignment();
    int h[MaxLen+1][MaxLen+1];
    logic [1:0] mv[MaxLen+1][MaxLen+1];
    int best, bi, bj, i, j, s_up, s_left, s_diag, c;
    column_t cols[$];
    column_t col;
    best = 0; bi = 0; bj = 0;
    for (i = 0; i <= MaxLen; i++)
      for (j = 0; j <= MaxLen; j++) begin
        h[i][j] = 0;
        mv[i][j] = MV_NONE;
      end
    for (i = 1; i <= len_a; i++)
      for (j = 1; j <= len_b; j++) begin
        s_up = h[i-1][j] + gap_val;
        s_left = h[i][j-1] + gap_val;
        s_diag = h[i-1][j-1] + ((seq_a[i-1] == seq_b[j-1]) ? match_val : mismatch_val);
        c = 0;
        if (s_up > c) c = s_up;
        if (s_left > c) c = s_left;
        if (s_diag > c) c = s_diag;
        if (c == s_up) mv[i][j] = MV_UP;
        else if (c == s_left) mv[i][j] = MV_LEFT;
        else mv[i][j] = MV_DIAG;
        h[i][j] = c;
        if ((i == 1 && j == 1) || c > best) begin
          best = c; bi = i; bj = j;
        end
      end
    i = bi; j = bj;
    while (i != 0 && j != 0 && h[i][j] != 0) begin
      col = '0;
      col.best_score = best[ScoreW-1:0];
      if (mv[i][j] == MV_DIAG) begin
        col.first_symbol = seq_a[i-1]; col.second_symbol = seq_b[j-1];
        i--; j--;
      end else if (mv[i][j] == MV_LEFT) begin
        col.first_symbol = GapChar; col.second_symbol = seq_b[j-1];
        col.first_is_gap = 1'b1;
        j--;
      end else begin
        col.first_symbol = seq_a[i-1]; col.second_symbol = GapChar;
        col.second_is_gap = 1'b1;
        i--;
      end
      cols.push_front(col);
    end
    len_a = 0; len_b = 0;
    if (cols.size() == 0) begin
      col = '0;
      col.best_score = best[ScoreW-1:0];
      col.empty_res = 1'b1;
      col.last = 1'b1;
      expected_columns.push_back(col);
    end else begin
      cols[cols.size()-1].last = 1'b1;
      foreach (cols[k]) expected_columns.push_back(cols[k]);
    end
  endfunction

  function automatic void predict_request(req_item_t r);
    case (r.req)
      REQ_FIRST: if (len_a < MaxLen) begin seq_a[len_a] = r.symbol; len_a++; end
      REQ_SECOND: if (len_b < MaxLen) begin seq_b[len_b] = r.symbol; len_b++; end
      REQ_RUN: begin
        predict_alignment();
        run_count++;
      end
      default: ;
    endcase
  endfunction

  // Driver: sends the queued requests, with bursts of idling until quiet is set.
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // An accepted item leaves the queue here, so the next one is always at the head.
      if (in_valid && !in_stall) begin
        predict_request('{req: req_type_i, symbol: symbol_i});
        void'(pending_reqs.pop_front());
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!(in_valid && in_stall)) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(1, 10);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_valid <= 1'b1;
          req_type_i <= pending_reqs[0].req;
          symbol_i <= pending_reqs[0].symbol;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor with receiver stalls and the long hold-off.
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        column_count++;
        if (expected_columns.size() == 0) begin
          $error("unexpected result: first_symbol %0d", first_symbol_o);
          error_count++;
        end else begin
          column_t e;
          e = expected_columns.pop_front();
          if (first_symbol_o !== e.first_symbol) begin
            $error("first_symbol expected %0d got %0d", e.first_symbol, first_symbol_o);
            error_count++;
          end
          if (second_symbol_o !== e.second_symbol) begin
            $error("second_symbol expected %0d got %0d", e.second_symbol, second_symbol_o);
            error_count++;
          end
          if (first_is_gap_o !== e.first_is_gap) begin
            $error("first_is_gap expected %0d got %0d", e.first_is_gap, first_is_gap_o);
            error_count++;
          end
          if (second_is_gap_o !== e.second_is_gap) begin
            $error("second_is_gap expected %0d got %0d", e.second_is_gap, second_is_gap_o);
            error_count++;
          end
          if (best_score_o !== e.best_score) begin
            $error("best_score expected %0d got %0d", e.best_score, best_score_o);
            error_count++;
          end
          if (empty_res_o !== e.empty_res) begin
            $error("empty_res expected %0d got %0d", e.empty_res, empty_res_o);
            error_count++;
          end
          if (last_o !== e.last) begin
            $error("last expected %0d got %0d", e.last, last_o);
            error_count++;
          end
        end
      end
      if (hold_request && !hold_active) begin
        hold_active <= 1'b1;
        hold_left <= 400;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_score(cfg_e idx, int value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[7:0];
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MATCH: match_val = value;
      CFG_MISMATCH: mismatch_val = value;
      default: gap_val = value;
    endcase
  endtask

  task automatic set_scores(int m, int mm, int g);
    write_score(CFG_MATCH, m);
    write_score(CFG_MISMATCH, mm);
    write_score(CFG_GAP, g);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_columns.size() > 0)
      @(posedge clk_i);
    // A trailing load or run may still be busy inside the block.
    repeat (2600) @(posedge clk_i);
  endtask

  task automatic queue_req(req_e r, logic [7:0] s);
    pending_reqs.push_back('{req: r, symbol: s});
  endtask

  // Random pair of sequences over a small alphabet, with occasional unknown requests, then a run.
  task automatic queue_random_run(int max_len);
    int na, nb, base;
    na = $urandom_range(0, max_len);
    nb = $urandom_range(0, max_len);
    base = $urandom_range(0, 255);
    for (int k = 0; k < na + nb; k++) begin
      if ($urandom_range(0, 15) == 0)
        queue_req(REQ_NONE, 8'($urandom));
      if (k < na)
        queue_req(REQ_FIRST, 8'(base ^ $urandom_range(0, 3)));
      else
        queue_req(REQ_SECOND, 8'(base ^ $urandom_range(0, 3)));
    end
    queue_req(REQ_RUN, 8'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty run, identical pair, unknown request, one-sided run, full sequences with overflow.
    queue_req(REQ_RUN, 8'h00);
    queue_req(REQ_FIRST, 8'h00); queue_req(REQ_FIRST, 8'hFF);
    queue_req(REQ_SECOND, 8'h00); queue_req(REQ_SECOND, 8'hFF);
    queue_req(REQ_NONE, 8'hAA);
    queue_req(REQ_RUN, 8'hFF);
    queue_req(REQ_FIRST, 8'h55); queue_req(REQ_RUN, 8'h00);
    for (int k = 0; k < 33; k++) queue_req(REQ_FIRST, 8'(k % 3));
    for (int k = 0; k < 33; k++) queue_req(REQ_SECOND, 8'((k + 1) % 3));
    queue_req(REQ_RUN, 8'h00);
    drain();

    // Long receiver hold-off while the sender keeps going.
    hold_request = 1'b1;
    for (int r = 0; r < 3; r++) queue_random_run(6);
    drain();
    hold_request = 1'b0;

    set_scores(127, -128, -128);
    queue_random_run(8);
    drain();
    set_scores(-128, 127, 127);
    queue_random_run(5);
    drain();
    set_scores(3, -2, -1);
    queue_random_run(10);
    drain();
    quiet = 1'b1;
    set_scores(2, -1, -2);
    queue_random_run(8);
    drain();

    $display("Covered %0d alignment runs and %0d aligned columns over several score settings.",
             run_count, column_count);
    if (error_count == 0 && expected_columns.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
